// ----- rtl/p25519_mod_multiply_unit_defines.svh -----
// Assertion macros for the p25519 multiply unit.
`ifndef P25519_MOD_MULTIPLY_UNIT_DEFINES_SVH
`define P25519_MOD_MULTIPLY_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define P25519_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define P25519_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);
`else
`define P25519_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define P25519_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

// ----- rtl/p25519_pkg.sv -----
`default_nettype none
package p25519_pkg;

    typedef enum logic [1:0] {
        REQ_MUL    = 2'd0,
        REQ_SQR    = 2'd1,
        REQ_FREEZE = 2'd2,
        REQ_NONE   = 2'd3
    } t_req_type;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] a_limb0;
        logic [63:0] a_limb1;
        logic [63:0] a_limb2;
        logic [63:0] a_limb3;
        logic [63:0] b_limb0;
        logic [63:0] b_limb1;
        logic [63:0] b_limb2;
        logic [63:0] b_limb3;
    } t_req;

    typedef struct packed {
        logic [63:0] r_limb0;
        logic [63:0] r_limb1;
        logic [63:0] r_limb2;
        logic [63:0] r_limb3;
    } t_rsp;

    localparam int FOLD_FACTOR = 38;
    localparam int FREEZE_ADD  = 19;
    localparam int LATENCY     = 8;

    // Clears bit 255 and adds 19 when it was set; carry out of the top is dropped.
    function automatic logic [255:0] clear_top_add19(input logic [255:0] x);
        logic [255:0] y;
        y = {1'b0, x[254:0]};
        return y + (x[255] ? 256'(FREEZE_ADD) : 256'd0);
    endfunction

    function automatic logic [255:0] freeze_final(input logic [255:0] x);
        logic        ge;
        logic [63:0] top_inc;
        logic [255:0] y;
        top_inc = x[255:192] + 64'd1;
        ge = (x[63:0] >= (64'd0 - 64'(FREEZE_ADD))) && (x[127:64] == '1) &&
             (x[191:128] == '1) && top_inc[63];
        y = ge ? (x + 256'(FREEZE_ADD)) : x;
        y[255] = 1'b0;
        return y;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/p25519_mod_multiply_unit.sv -----
// Channel   Ports                        Handshake
// request   start, busy, i_req           beat taken when start && !busy
// result    o_done, o_rsp                one-cycle beat, always taken
//
// One beat may enter every cycle; busy is always low.
// Each result passes through the stage registers and leaves in issue order.
// The depth is set by the 32x32 partial-product array, column adders and fold adders.
// Reset clears the valid bits only; data registers are not reset.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none
`include "p25519_mod_multiply_unit_defines.svh"
module p25519_mod_multiply_unit (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire p25519_pkg::t_req  i_req,
    output logic                   o_done,
    output p25519_pkg::t_rsp       o_rsp
);

    logic [7:0]   r_v;
    logic [1:0]   r1_op, r2_op, r3_op, r4_op, r5_op, r6_op, r7_op;
    logic [255:0] r1_a, r1_b, r2_a, r3_a, r4_a, r5_a, r6_f, r7_f;
    logic [63:0]  r2_pp [8][8];
    logic [66:0]  r3_col [15];
    logic [66:0]  n_col [15];
    logic [511:0] r4_e, r4_o, n_e, n_o, r5_p;
    logic [261:0] r6_t, n_t;
    logic [256:0] r7_s;
    logic [255:0] n_res;
    p25519_pkg::t_rsp r_rsp;

    assign busy   = 1'b0;
    assign o_done = r_v[7];
    assign o_rsp  = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[6:0], start && !busy};
        end
    end

    // Stage 1: capture operands; squaring uses a for both.
    always_ff @(posedge i_clk) begin
        r1_op <= i_req.req_type;
        r1_a  <= {i_req.a_limb3, i_req.a_limb2, i_req.a_limb1, i_req.a_limb0};
        if (i_req.req_type == p25519_pkg::REQ_SQR) begin
            r1_b <= {i_req.a_limb3, i_req.a_limb2, i_req.a_limb1, i_req.a_limb0};
        end else begin
            r1_b <= {i_req.b_limb3, i_req.b_limb2, i_req.b_limb1, i_req.b_limb0};
        end
    end

    // Stage 2: 64 partial products of 32-bit halves.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 8; i++) begin
            for (int j = 0; j < 8; j++) begin
                r2_pp[i][j] <= 64'(r1_a[32*i +: 32]) * 64'(r1_b[32*j +: 32]);
            end
        end
        r2_op <= r1_op;
        r2_a  <= r1_a;
    end

    // Stage 3: sum each 32-bit column.
    always_comb begin
        for (int k = 0; k < 15; k++) begin
            n_col[k] = '0;
        end
        for (int i = 0; i < 8; i++) begin
            for (int j = 0; j < 8; j++) begin
                n_col[i+j] = n_col[i+j] + {3'b0, r2_pp[i][j]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r3_col <= n_col;
        r3_op  <= r2_op;
        r3_a   <= r2_a;
    end

    // Stage 4: even and odd columns overlap only in their top bits.
    always_comb begin
        n_e = '0;
        n_o = '0;
        for (int k = 0; k < 15; k++) begin
            if (k % 2 == 0) begin
                n_e = n_e + (512'(r3_col[k]) << (32 * k));
            end else begin
                n_o = n_o + (512'(r3_col[k]) << (32 * k));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r4_e  <= n_e;
        r4_o  <= n_o;
        r4_op <= r3_op;
        r4_a  <= r3_a;
    end

    // Stage 5: full 512-bit product.
    always_ff @(posedge i_clk) begin
        r5_p  <= r4_e + r4_o;
        r5_op <= r4_op;
        r5_a  <= r4_a;
    end

    // Stage 6: fold the upper half with 38 = 32 + 4 + 2.
    always_comb begin
        n_t = {6'b0, r5_p[255:0]} + ({6'b0, r5_p[511:256]} << 5) +
              ({6'b0, r5_p[511:256]} << 2) + ({6'b0, r5_p[511:256]} << 1);
    end

    always_ff @(posedge i_clk) begin
        r6_t  <= n_t;
        r6_f  <= p25519_pkg::clear_top_add19(r5_a);
        r6_op <= r5_op;
    end

    // Stage 7: fold the small carry word.
    always_ff @(posedge i_clk) begin
        r7_s  <= {1'b0, r6_t[255:0]} + 257'(r6_t[261:256]) * 257'(p25519_pkg::FOLD_FACTOR);
        r7_f  <= p25519_pkg::clear_top_add19(r6_f);
        r7_op <= r6_op;
    end

    // Stage 8: mul/sqr: carry out of bit 255 adds 38; freeze: freeze_final; else 0.
    always_comb begin
        case (r7_op)
            p25519_pkg::REQ_MUL, p25519_pkg::REQ_SQR: begin
                n_res = r7_s[255:0] +
                        (r7_s[256] ? 256'(p25519_pkg::FOLD_FACTOR) : 256'd0);
            end
            p25519_pkg::REQ_FREEZE: n_res = p25519_pkg::freeze_final(r7_f);
            default:                n_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rsp.r_limb0 <= n_res[63:0];
        r_rsp.r_limb1 <= n_res[127:64];
        r_rsp.r_limb2 <= n_res[191:128];
        r_rsp.r_limb3 <= n_res[255:192];
    end

    `P25519_ASSERT_IMP(a_done_follows_start, i_clk, i_rst_n, o_done, $past(start, p25519_pkg::LATENCY), "result beat without a request beat")
    `P25519_ASSERT_IMP(a_none_zero, i_clk, i_rst_n, o_done && $past(i_req.req_type == p25519_pkg::REQ_NONE, p25519_pkg::LATENCY), o_rsp == '0, "unknown request gave a nonzero result")
    `P25519_ASSERT_IMP(a_freeze_canon, i_clk, i_rst_n, o_done && $past(i_req.req_type == p25519_pkg::REQ_FREEZE, p25519_pkg::LATENCY), !o_rsp.r_limb3[63], "frozen result has bit 255 set")
    `P25519_ASSERT_NEVER(a_never_busy, i_clk, i_rst_n, busy, "busy raised")

endmodule
`default_nettype wire
